// ===== rtl/ray_box_slab_intersect_defines.svh =====
// Assertion macros for the ray / box intersection RTL
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RBSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Register indexes and fixed sizes for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

    localparam int AXES     = 3;
    localparam int DIVS     = 6;
    localparam int IDX_BITS = 3;
    localparam int EPS_BITS = 16;

    localparam logic [IDX_BITS-1:0] CFG_CORNER_A_X = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_CORNER_A_Y = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_CORNER_A_Z = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_CORNER_B_X = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_CORNER_B_Y = 3'd4;
    localparam logic [IDX_BITS-1:0] CFG_CORNER_B_Z = 3'd5;
    localparam logic [IDX_BITS-1:0] CFG_EPSILON    = 3'd6;

    typedef logic [1:0] t_axis;

endpackage

`default_nettype wire

// ===== rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// Ray / axis-aligned box slab intersection
// Tests one ray per cycle, while the output is not stalled, against a box held in configuration registers.
// ----------------------------------------------------------------------------
// Each request passes through a fixed pipeline of COORD_BITS+FRAC_BITS+6
// stages (54 at the default sizes), one result per request, in order. The
// length is set by the six restoring dividers, which resolve one quotient
// bit per stage; after them come interval sort, slab reduction, the
// distance multiply and the hit point add. With o_valid taken each cycle a
// new request is accepted every cycle. The whole pipeline holds while a
// result waits at the output. Write the box and epsilon only while idle.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [rbsi_pkg::IDX_BITS-1:0]         i_cfg_idx,
    input  wire  [COORD_BITS-1:0]                 i_cfg_data,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [COORD_BITS-1:0]          i_origin_x,
    input  wire  signed [COORD_BITS-1:0]          i_origin_y,
    input  wire  signed [COORD_BITS-1:0]          i_origin_z,
    input  wire  signed [COORD_BITS-1:0]          i_dir_x,
    input  wire  signed [COORD_BITS-1:0]          i_dir_y,
    input  wire  signed [COORD_BITS-1:0]          i_dir_z,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic                                  o_hit,
    output logic [COORD_BITS-2:0]                 o_hit_distance,
    output logic signed [COORD_BITS-1:0]          o_point_x,
    output logic signed [COORD_BITS-1:0]          o_point_y,
    output logic signed [COORD_BITS-1:0]          o_point_z,
    output logic signed [COORD_BITS-1:0]          o_normal_x,
    output logic signed [COORD_BITS-1:0]          o_normal_y,
    output logic signed [COORD_BITS-1:0]          o_normal_z
);
    import rbsi_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int FW = FRAC_BITS;
    localparam int QW = CW + FW + 1;
    localparam int PW = 2 * CW;

    localparam logic [CW:0] T_NEG_INF = {1'b1, {CW{1'b0}}};
    localparam logic [CW:0] T_POS_INF = {1'b0, {CW{1'b1}}};
    localparam logic [CW-1:0] C_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE_FX  = {{(CW-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};
    localparam logic [QW-1:0] Q_MAXMAG = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MINMAG = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
    localparam logic [PW-1:0] P_MAX   = {{(CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [PW-1:0] P_MIN   = {{(CW+1){1'b1}}, {(CW-1){1'b0}}};

    // configuration
    logic [CW-1:0]       r_ca [AXES];
    logic [CW-1:0]       r_cb [AXES];
    logic [EPS_BITS-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_ca[a] <= '0;
                r_cb[a] <= ONE_FX;
            end
            r_eps <= {{(EPS_BITS-1){1'b0}}, 1'b1};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CORNER_A_X: r_ca[0] <= i_cfg_data;
                CFG_CORNER_A_Y: r_ca[1] <= i_cfg_data;
                CFG_CORNER_A_Z: r_ca[2] <= i_cfg_data;
                CFG_CORNER_B_X: r_cb[0] <= i_cfg_data;
                CFG_CORNER_B_Y: r_cb[1] <= i_cfg_data;
                CFG_CORNER_B_Z: r_cb[2] <= i_cfg_data;
                CFG_EPSILON:    r_eps   <= i_cfg_data[EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic r_ov;
    logic w_en;
    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    logic [CW-1:0] w_org [AXES];
    logic [CW-1:0] w_dir [AXES];
    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    // divider pipeline storage, stage 0 is the entry register
    logic          r_dv    [0:QW];
    logic          r_dcrn  [0:QW];
    logic [CW-1:0] r_dorg  [0:QW][AXES];
    logic [CW-1:0] r_ddir  [0:QW][AXES];
    logic          r_dzero [0:QW][AXES];
    logic [CW-1:0] r_den   [0:QW][AXES];
    logic [QW-1:0] r_num   [0:QW][DIVS];
    logic [CW-1:0] r_rem   [0:QW][DIVS];
    logic [QW-1:0] r_q     [0:QW][DIVS];
    logic          r_qneg  [0:QW][DIVS];

    // entry: offsets to the corners, nearness tests, divider operands
    logic signed [CW:0] s_da [AXES];
    logic signed [CW:0] s_db [AXES];
    logic [CW:0]        s_ma [AXES];
    logic [CW:0]        s_mb [AXES];
    logic [CW:0]        s_md [AXES];
    logic [CW:0]        s_eps;
    logic               s_near_a;
    logic               s_near_b;

    always_comb begin
        s_eps    = {{(CW+1-EPS_BITS){1'b0}}, r_eps};
        s_near_a = 1'b1;
        s_near_b = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            s_da[a] = $signed({r_ca[a][CW-1], r_ca[a]}) - $signed({w_org[a][CW-1], w_org[a]});
            s_db[a] = $signed({r_cb[a][CW-1], r_cb[a]}) - $signed({w_org[a][CW-1], w_org[a]});
            s_ma[a] = s_da[a][CW] ? (CW+1)'(-s_da[a]) : s_da[a];
            s_mb[a] = s_db[a][CW] ? (CW+1)'(-s_db[a]) : s_db[a];
            s_md[a] = w_dir[a][CW-1] ? (CW+1)'(-$signed({w_dir[a][CW-1], w_dir[a]}))
                                     : {1'b0, w_dir[a]};
            if (s_ma[a] > s_eps) s_near_a = 1'b0;
            if (s_mb[a] > s_eps) s_near_b = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dcrn[0] <= s_near_a && s_near_b;
            for (int a = 0; a < AXES; a++) begin
                r_dorg[0][a]  <= w_org[a];
                r_ddir[0][a]  <= w_dir[a];
                r_dzero[0][a] <= s_md[a] <= s_eps;
                r_den[0][a]   <= s_md[a][CW-1:0];
                r_num[0][a]       <= {s_ma[a], {FW{1'b0}}};
                r_num[0][a+AXES]  <= {s_mb[a], {FW{1'b0}}};
                r_qneg[0][a]      <= s_da[a][CW] ^ w_dir[a][CW-1];
                r_qneg[0][a+AXES] <= s_db[a][CW] ^ w_dir[a][CW-1];
            end
            for (int j = 0; j < DIVS; j++) begin
                r_rem[0][j] <= '0;
                r_q[0][j]   <= '0;
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [CW:0]   n_trial [DIVS];
        logic [CW:0]   n_diff  [DIVS];
        logic [CW-1:0] n_rem   [DIVS];
        logic [QW-1:0] n_q     [DIVS];

        always_comb begin
            for (int j = 0; j < DIVS; j++) begin
                n_trial[j] = {r_rem[k][j], r_num[k][j][QW-1-k]};
                n_diff[j]  = n_trial[j] - {1'b0, r_den[k][j % AXES]};
                n_q[j]     = r_q[k][j];
                if (n_trial[j] >= {1'b0, r_den[k][j % AXES]}) begin
                    n_rem[j]        = n_diff[j][CW-1:0];
                    n_q[j][QW-1-k]  = 1'b1;
                end else begin
                    n_rem[j] = n_trial[j][CW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dcrn[k+1] <= r_dcrn[k];
                r_dorg[k+1] <= r_dorg[k];
                r_ddir[k+1] <= r_ddir[k];
                r_dzero[k+1] <= r_dzero[k];
                r_den[k+1]  <= r_den[k];
                r_num[k+1]  <= r_num[k];
                r_rem[k+1]  <= n_rem;
                r_q[k+1]    <= n_q;
                r_qneg[k+1] <= r_qneg[k];
            end
        end
    end

    // sign, saturate and order each slab interval
    logic [QW-1:0]      n_negq [DIVS];
    logic [CW-1:0]      n_t    [DIVS];
    logic signed [CW:0] n_lo   [AXES];
    logic signed [CW:0] n_hi   [AXES];

    always_comb begin
        for (int j = 0; j < DIVS; j++) begin
            n_negq[j] = ~r_q[QW][j] + {{(QW-1){1'b0}}, 1'b1};
            if (!r_qneg[QW][j]) begin
                n_t[j] = (r_q[QW][j] > Q_MAXMAG) ? C_MAX : r_q[QW][j][CW-1:0];
            end else begin
                n_t[j] = (r_q[QW][j] > Q_MINMAG) ? C_MIN : n_negq[j][CW-1:0];
            end
        end
        for (int a = 0; a < AXES; a++) begin
            if (r_dzero[QW][a]) begin
                n_lo[a] = T_NEG_INF;
                n_hi[a] = T_POS_INF;
            end else if ($signed(n_t[a]) > $signed(n_t[a+AXES])) begin
                n_lo[a] = {n_t[a+AXES][CW-1], n_t[a+AXES]};
                n_hi[a] = {n_t[a][CW-1], n_t[a]};
            end else begin
                n_lo[a] = {n_t[a][CW-1], n_t[a]};
                n_hi[a] = {n_t[a+AXES][CW-1], n_t[a+AXES]};
            end
        end
    end

    logic               r_bv;
    logic               r_bcrn;
    logic [CW-1:0]      r_borg [AXES];
    logic [CW-1:0]      r_bdir [AXES];
    logic signed [CW:0] r_lo   [AXES];
    logic signed [CW:0] r_hi   [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (w_en) begin
            r_bv <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bcrn <= r_dcrn[QW];
            r_borg <= r_dorg[QW];
            r_bdir <= r_ddir[QW];
            r_lo   <= n_lo;
            r_hi   <= n_hi;
        end
    end

    // latest entry (lowest axis on a tie) and earliest exit
    logic signed [CW:0] n_entry;
    logic signed [CW:0] n_exit;
    t_axis              n_axis;

    always_comb begin
        n_entry = r_lo[0];
        n_exit  = r_hi[0];
        n_axis  = 2'd0;
        for (int a = 1; a < AXES; a++) begin
            if (r_lo[a] > n_entry) begin
                n_entry = r_lo[a];
                n_axis  = t_axis'(a);
            end
            if (r_hi[a] < n_exit) n_exit = r_hi[a];
        end
    end

    logic          r_cv;
    logic          r_ccrn;
    logic          r_chit;
    t_axis         r_caxis;
    logic [CW-1:0] r_centry;
    logic [CW-1:0] r_corg [AXES];
    logic [CW-1:0] r_cdir [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (w_en) begin
            r_cv <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ccrn   <= r_bcrn;
            r_chit   <= !(n_entry[CW] || (n_entry > n_exit));
            r_caxis  <= n_axis;
            r_centry <= n_entry[CW-1:0];
            r_corg   <= r_borg;
            r_cdir   <= r_bdir;
        end
    end

    // distance times direction
    logic          r_mv;
    logic          r_mcrn;
    logic          r_mhit;
    t_axis         r_maxis;
    logic [CW-1:0] r_mentry;
    logic [CW-1:0] r_morg  [AXES];
    logic [CW-1:0] r_mdir  [AXES];
    logic [PW-1:0] r_prod  [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_en) begin
            r_mv <= r_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mcrn   <= r_ccrn;
            r_mhit   <= r_chit;
            r_maxis  <= r_caxis;
            r_mentry <= r_centry;
            r_morg   <= r_corg;
            r_mdir   <= r_cdir;
            for (int a = 0; a < AXES; a++) begin
                r_prod[a] <= $signed(r_cdir[a]) * $signed(r_centry);
            end
        end
    end

    // hit point, normals and the origin-at-both-corners case
    logic signed [PW-1:0] n_sum  [AXES];
    logic [CW-1:0]        n_pt   [AXES];
    logic [CW-1:0]        n_nrm  [AXES];
    logic [CW-1:0]        n_ndir [AXES];
    logic                 n_hit;
    logic [CW-2:0]        n_dist;

    always_comb begin
        n_hit  = r_mcrn || r_mhit;
        n_dist = (r_mcrn || !r_mhit) ? '0 : r_mentry[CW-2:0];
        for (int a = 0; a < AXES; a++) begin
            n_sum[a]  = ($signed(r_prod[a]) >>> FW)
                        + $signed({{CW{r_morg[a][CW-1]}}, r_morg[a]});
            n_ndir[a] = (r_mdir[a] == C_MIN) ? C_MAX : CW'(-$signed(r_mdir[a]));
            if (r_mcrn) begin
                n_pt[a]  = r_ca[a];
                n_nrm[a] = n_ndir[a];
            end else if (!r_mhit) begin
                n_pt[a]  = '0;
                n_nrm[a] = '0;
            end else begin
                if (n_sum[a] > $signed(P_MAX)) n_pt[a] = C_MAX;
                else if (n_sum[a] < $signed(P_MIN)) n_pt[a] = C_MIN;
                else n_pt[a] = n_sum[a][CW-1:0];
                n_nrm[a] = (r_maxis == t_axis'(a)) ? ONE_FX : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit          <= n_hit;
            o_hit_distance <= n_dist;
            o_point_x      <= n_pt[0];
            o_point_y      <= n_pt[1];
            o_point_z      <= n_pt[2];
            o_normal_x     <= n_nrm[0];
            o_normal_y     <= n_nrm[1];
            o_normal_z     <= n_nrm[2];
        end
    end

    assign o_valid = r_ov;

`include "ray_box_slab_intersect_defines.svh"

    `RBSI_ASSERT_NOW(a_miss_zero, o_valid && !o_hit, (o_hit_distance == '0) && (o_point_x == '0) && (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0), "miss with non-zero fields")
    `RBSI_ASSERT_NOW(a_slab_order, r_bv, (r_lo[0] <= r_hi[0]) && (r_lo[1] <= r_hi[1]) && (r_lo[2] <= r_hi[2]), "slab interval not ordered")
    `RBSI_ASSERT_NEXT(a_hold_stall, o_valid && !i_ready, o_valid && $stable(o_hit) && $stable(o_point_x), "result lost under stall")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Ray / box slab intersection testbench
// Drives rays through the block against several box and epsilon settings and
// checks each result against a predictor of the slab test, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rbsi_pkg::*;

    localparam int  CB      = 32;
    localparam int  FB      = 16;
    localparam int  LAT     = CB + FB + 6;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    typedef struct packed {
        logic [CB-1:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic          hit;
        logic [CB-2:0] hdist;
        logic [CB-1:0] px, py, pz, nx, ny, nz;
    } isect_t;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_cfg_we = 0;
    logic [IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CB-1:0]   i_cfg_data = '0;
    logic            i_valid = 0;
    logic            o_ready;
    logic [CB-1:0]   i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic [CB-1:0]   i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic            o_valid;
    logic            i_ready = 0;
    logic            o_hit;
    logic [CB-2:0]   o_hit_distance;
    logic [CB-1:0]   o_point_x, o_point_y, o_point_z;
    logic [CB-1:0]   o_normal_x, o_normal_y, o_normal_z;

    ray_box_slab_intersect dut (.*);

    // box state kept by the predictor
    longint box_a [3];
    longint box_b [3];
    longint eps;

    ray_t   ray_q [$];
    isect_t isect_q [$];
    int     n_err = 0;
    int     burst = 0, gap = 0;
    int     stall_ph = 0;
    bit     hold_tx = 0;

    initial forever #6 i_clk = ~i_clk;

    function automatic longint sat(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic isect_t predict_isect(ray_t r);
        isect_t res;
        longint org [3], dir [3], lo [3], hi [3];
        longint ent, ext, t, p;
        bit na, nb;
        int ax;
        res = '0;
        na = 1;
        nb = 1;
        org[0] = longint'($signed(r.ox)); org[1] = longint'($signed(r.oy));
        org[2] = longint'($signed(r.oz));
        dir[0] = longint'($signed(r.dx)); dir[1] = longint'($signed(r.dy));
        dir[2] = longint'($signed(r.dz));
        for (int i = 0; i < 3; i++) begin
            if (mag(org[i] - box_a[i]) > eps) na = 0;
            if (mag(org[i] - box_b[i]) > eps) nb = 0;
        end
        if (na && nb) begin
            res.hit = 1;
            res.px = box_a[0][CB-1:0]; res.py = box_a[1][CB-1:0];
            res.pz = box_a[2][CB-1:0];
            p = sat(-dir[0]); res.nx = p[CB-1:0];
            p = sat(-dir[1]); res.ny = p[CB-1:0];
            p = sat(-dir[2]); res.nz = p[CB-1:0];
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            if (mag(dir[i]) <= eps) begin
                lo[i] = 64'h8000_0000_0000_0000;
                hi[i] = 64'h7fff_ffff_ffff_ffff;
            end else begin
                lo[i] = sat(((box_a[i] - org[i]) * (64'sd1 << FB)) / dir[i]);
                hi[i] = sat(((box_b[i] - org[i]) * (64'sd1 << FB)) / dir[i]);
                if (lo[i] > hi[i]) begin
                    t = lo[i]; lo[i] = hi[i]; hi[i] = t;
                end
            end
        end
        ax = 0; ent = lo[0]; ext = hi[0];
        for (int i = 1; i < 3; i++) begin
            if (lo[i] > ent) begin
                ent = lo[i]; ax = i;
            end
            if (hi[i] < ext) ext = hi[i];
        end
        if (ent < 0 || ent > ext) return res;
        res.hit = 1;
        res.hdist = ent[CB-2:0];
        for (int i = 0; i < 3; i++) begin
            t = dir[i] * ent;
            // floor of the fixed-point product
            t = (t >= 0) ? (t >>> FB) : -((-t + (64'sd1 << FB) - 1) >>> FB);
            p = sat(org[i] + t);
            case (i)
                0: res.px = p[CB-1:0];
                1: res.py = p[CB-1:0];
                default: res.pz = p[CB-1:0];
            endcase
        end
        case (ax)
            0: res.nx = 32'h0001_0000;
            1: res.ny = 32'h0001_0000;
            default: res.nz = 32'h0001_0000;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] exp);
        n_err++;
        $display("mismatch %s: got %h exp %h", what, got, exp);
    endtask

    // driver: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && o_ready) begin
                isect_q.push_back(predict_isect({i_origin_x, i_origin_y, i_origin_z,
                                                 i_dir_x, i_dir_y, i_dir_z}));
            end
            if (!i_valid || o_ready) begin
                if (gap > 0) begin
                    gap--;
                    i_valid <= 0;
                end else if (ray_q.size() > 0 && !hold_tx) begin
                    ray_t r;
                    r = ray_q.pop_front();
                    {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z} <= r;
                    i_valid <= 1;
                    if (burst > 0) begin
                        burst--;
                    end else begin
                        burst = $urandom_range(0, 20);
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                isect_t e;
                if (isect_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    e = isect_q.pop_front();
                    if (o_hit !== e.hit) report_mismatch("hit", o_hit, e.hit);
                    if (o_hit_distance !== e.hdist)
                        report_mismatch("hit_distance", o_hit_distance, e.hdist);
                    if (o_point_x !== e.px) report_mismatch("point_x", o_point_x, e.px);
                    if (o_point_y !== e.py) report_mismatch("point_y", o_point_y, e.py);
                    if (o_point_z !== e.pz) report_mismatch("point_z", o_point_z, e.pz);
                    if (o_normal_x !== e.nx) report_mismatch("normal_x", o_normal_x, e.nx);
                    if (o_normal_y !== e.ny) report_mismatch("normal_y", o_normal_y, e.ny);
                    if (o_normal_z !== e.nz) report_mismatch("normal_z", o_normal_z, e.nz);
                end
            end
            stall_ph = (stall_ph + 1) % 64;
            if (stall_ph < 24) i_ready <= 1;
            else if (stall_ph < 40) i_ready <= ($urandom_range(0, 2) != 0);
            else i_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // the caller drops the write enable after the last write
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CB-1:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < 3) box_a[idx] = longint'($signed(val));
        else if (idx < 6) box_b[idx-3] = longint'($signed(val));
        else eps = longint'(val[15:0]);
    endtask

    task automatic wait_drained();
        while (ray_q.size() > 0 || i_valid || isect_q.size() > 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic set_box(longint ax, longint ay, longint az,
                           longint bx, longint by, longint bz, longint e);
        write_reg(CFG_CORNER_A_X, ax[CB-1:0]);
        write_reg(CFG_CORNER_A_Y, ay[CB-1:0]);
        write_reg(CFG_CORNER_A_Z, az[CB-1:0]);
        write_reg(CFG_CORNER_B_X, bx[CB-1:0]);
        write_reg(CFG_CORNER_B_Y, by[CB-1:0]);
        write_reg(CFG_CORNER_B_Z, bz[CB-1:0]);
        write_reg(CFG_EPSILON, e[CB-1:0]);
        i_cfg_we <= 0;
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic ray_t aimed_ray();
        ray_t r;
        longint tg, o, d;
        logic [CB-1:0] v [6];
        for (int i = 0; i < 3; i++) begin
            // target inside the box, origin a few units away
            tg = box_a[i] + ((box_b[i] - box_a[i]) * longint'($urandom_range(0, 100))) / 100;
            o = sat(tg + ($signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000));
            d = sat(tg - o);
            if ($urandom_range(0, 7) == 0) d = $signed($urandom_range(0, 6)) - 3;
            v[i] = o[CB-1:0];
            v[3+i] = d[CB-1:0];
        end
        r = {v[0], v[1], v[2], v[3], v[4], v[5]};
        return r;
    endfunction

    task automatic random_rays(int n);
        ray_t r;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                r = aimed_ray();
            end else begin
                r = {rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord(), rnd_coord(), rnd_coord()};
            end
            ray_q.push_back(r);
        end
    endtask

    initial begin
        box_a = '{0, 0, 0};
        box_b = '{65536, 65536, 65536};
        eps = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed rays against the reset box
        ray_q.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'sh1});
        ray_q.push_back({32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0});
        ray_q.push_back({-32'sh0001_0000, 32'h0000_8000, 32'h0000_8000,
                         32'h0001_0000, 32'h0, 32'h0});
        ray_q.push_back({32'h0000_8000, -32'sh0001_0000, 32'h0000_8000,
                         32'h0, 32'h0002_0000, 32'h0000_0001});
        ray_q.push_back({32'h0000_8000, 32'h0000_8000, 32'h0003_0000,
                         32'h0, 32'h0, -32'sh0001_0000});
        ray_q.push_back({-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
                         32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        ray_q.push_back({32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                         32'h7fff_ffff, 32'h8000_0000, 32'h0000_0002});
        ray_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        ray_q.push_back({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        ray_q.push_back({32'h0003_0000, 32'h0000_8000, 32'h0000_8000,
                         32'h0001_0000, 32'h0, 32'h0});
        ray_q.push_back({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        wait_drained();

        // corners within epsilon of each other: origin near both corners
        set_box(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                32'sh0001_0002, 32'sh0001_0002, 32'sh0001_0002, 4);
        ray_q.push_back({32'h0001_0001, 32'h0001_0001, 32'h0001_0001,
                         32'h8000_0000, 32'h7fff_ffff, 32'h0000_1234});
        ray_q.push_back({32'h0001_0001, 32'h0001_0001, 32'h0001_0001,
                         32'h0001_0000, 32'h0, 32'h0});
        random_rays(150);
        // hold the sender mid-stream until every result is back
        while (ray_q.size() > 75) @(posedge i_clk);
        hold_tx = 1;
        while (i_valid || isect_q.size() > 0) @(posedge i_clk);
        hold_tx = 0;
        wait_drained();

        set_box(-32'sh0010_0000, -32'sh0008_0000, 32'sh0002_0000,
                32'sh0004_0000, 32'sh0010_0000, -32'sh0003_0000, 32'h0000_0100);
        random_rays(200);
        wait_drained();

        set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16'hffff);
        random_rays(150);
        wait_drained();

        set_box(CMAX, CMIN, 0, CMIN, CMAX, 32'sh0000_0010, 0);
        random_rays(150);
        wait_drained();

        set_box(0, 0, 0, 32'sh0002_0000, 32'sh0001_0000, 32'sh0000_8000,
                $urandom_range(0, 65535));
        random_rays(150);
        wait_drained();

        if (n_err == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("tb NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rbsi_pkg.sv
rtl/ray_box_slab_intersect.sv
dv/tb.sv
